/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/rod_pkg.sv */
// ----------------------------------------------------------------------------
// rod_pkg
// Types and constants of the ray / oriented-box exit distance pipeline.
// ----------------------------------------------------------------------------
package rod_pkg;

  // Field widths
  localparam int unsigned CRD_W   = 16;  // Q8.8 coordinate
  localparam int unsigned UNIT_W  = 16;  // Q1.14 direction / quaternion
  localparam int unsigned RAD_W   = 15;  // grow radius
  localparam int unsigned HEP_W   = 48;  // packed half extents
  localparam int unsigned DIST_W  = 16;  // exit distance

  // Datapath widths
  localparam int unsigned V_W     = 17;  // origin minus center
  localparam int unsigned EXT_W   = 17;  // grown half extent
  localparam int unsigned E16_W   = EXT_W + 8;
  localparam int unsigned QP_W    = 32;  // quaternion products
  localparam int unsigned R_W     = 34;  // rotation matrix entry, Q28
  localparam int unsigned RS_W    = R_W + 2;
  localparam int unsigned PV_W    = R_W + V_W - 1;
  localparam int unsigned PD_W    = R_W + UNIT_W - 1;
  localparam int unsigned SV_W    = PV_W + 2;
  localparam int unsigned SD_W    = PD_W + 2;
  localparam int unsigned LOC_SH  = 20;
  localparam int unsigned DIR_SH  = 12;
  localparam int unsigned LOC_W   = 32;  // local offset, Q16
  localparam int unsigned DIR_W   = 39;  // local direction, Q30
  localparam int unsigned NUM_W   = 32;  // slab numerator magnitude
  localparam int unsigned FRAC_SH = 22;
  localparam int unsigned DVD_W   = NUM_W + FRAC_SH;
  localparam int unsigned DEN_W   = DIR_W - 1;
  localparam int unsigned QUO_W   = 43;
  localparam int unsigned QT_W    = QUO_W + 1;

  // Pipeline depth
  localparam int unsigned PRE_STAGES  = 6;
  localparam int unsigned DIV_STEPS   = QUO_W;
  localparam int unsigned PIPE_STAGES = PRE_STAGES + DIV_STEPS + 2;

  localparam logic signed [RS_W-1:0] ONE_Q28 = RS_W'(64'sh1000_0000);
  localparam int unsigned PARALLEL_LIMIT = 1074;  // 1e-6 in Q30
  localparam logic [DIST_W-1:0] EXIT_MAX = '1;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X    = 2'd0,
    CFG_ORIGIN_Y    = 2'd1,
    CFG_ORIGIN_Z    = 2'd2,
    CFG_GROW_RADIUS = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic signed [UNIT_W-1:0] dir_x;
    logic signed [UNIT_W-1:0] dir_y;
    logic signed [UNIT_W-1:0] dir_z;
    logic signed [CRD_W-1:0]  box_center_x;
    logic signed [CRD_W-1:0]  box_center_y;
    logic signed [CRD_W-1:0]  box_center_z;
    logic [HEP_W-1:0]         half_extents_packed;
    logic signed [UNIT_W-1:0] quat_w;
    logic signed [UNIT_W-1:0] quat_x;
    logic signed [UNIT_W-1:0] quat_y;
    logic signed [UNIT_W-1:0] quat_z;
  } in_item_t;

  typedef struct packed {
    logic [DIST_W-1:0] exit_distance;
    logic              box_hit;
  } out_item_t;

  // One axis into the slab divider
  typedef struct packed {
    logic [NUM_W-1:0] lo_mag;
    logic             lo_qneg;
    logic [NUM_W-1:0] hi_mag;
    logic             hi_qneg;
    logic [DEN_W-1:0] den_mag;
    logic             swap;
    logic             par;
    logic             in_slab;
  } slab_in_t;

  // One axis out of the slab divider
  typedef struct packed {
    logic [QUO_W-1:0] lo_mag;
    logic             lo_qneg;
    logic [QUO_W-1:0] hi_mag;
    logic             hi_qneg;
    logic             swap;
    logic             par;
    logic             in_slab;
  } slab_out_t;

endpackage

/* rtl/rod_slab_div.sv */
// ----------------------------------------------------------------------------
// rod_slab_div
// Pipelined restoring divider for both slab bounds of one axis, one quotient
// bit per stage, sharing the divisor.
// ----------------------------------------------------------------------------
module rod_slab_div (
  input  logic               clk_i,
  input  logic               en_i,
  input  rod_pkg::slab_in_t  slab_i,
  output rod_pkg::slab_out_t slab_o
);
  import rod_pkg::*;

  localparam int unsigned HeadW = DVD_W - QUO_W;

  typedef struct packed {
    logic [DEN_W-1:0] rem;
    logic [DVD_W-1:0] dvd;
    logic [QUO_W-1:0] quo;
  } lane_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             lo_qneg;
    logic             hi_qneg;
    logic             swap;
    logic             par;
    logic             in_slab;
  } side_t;

  function automatic lane_t div_step(lane_t l, logic [DEN_W-1:0] den);
    lane_t        r;
    logic [DEN_W:0] trial;
    logic         take;
    trial = {l.rem, l.dvd[DVD_W-1]};
    take  = (trial >= {1'b0, den});
    r.rem = take ? DEN_W'(trial - {1'b0, den}) : trial[DEN_W-1:0];
    r.dvd = {l.dvd[DVD_W-2:0], 1'b0};
    r.quo = {l.quo[QUO_W-2:0], take};
    return r;
  endfunction

  function automatic lane_t lane_init(logic [NUM_W-1:0] mag);
    lane_t            r;
    logic [DVD_W-1:0] full;
    full  = {mag, FRAC_SH'(0)};
    r.rem = DEN_W'(full[DVD_W-1 -: HeadW]);
    r.dvd = full << HeadW;
    r.quo = '0;
    return r;
  endfunction

  lane_t lo_init, hi_init;
  side_t side_init;
  lane_t lo_q   [DIV_STEPS];
  lane_t hi_q   [DIV_STEPS];
  side_t side_q [DIV_STEPS];

  always_comb begin
    lo_init          = lane_init(slab_i.lo_mag);
    hi_init          = lane_init(slab_i.hi_mag);
    side_init.den    = slab_i.den_mag;
    side_init.lo_qneg = slab_i.lo_qneg;
    side_init.hi_qneg = slab_i.hi_qneg;
    side_init.swap   = slab_i.swap;
    side_init.par    = slab_i.par;
    side_init.in_slab = slab_i.in_slab;
  end

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[i]   <= div_step(lo_init, side_init.den);
          hi_q[i]   <= div_step(hi_init, side_init.den);
          side_q[i] <= side_init;
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        if (en_i) begin
          lo_q[i]   <= div_step(lo_q[i-1], side_q[i-1].den);
          hi_q[i]   <= div_step(hi_q[i-1], side_q[i-1].den);
          side_q[i] <= side_q[i-1];
        end
      end
    end
  end

  assign slab_o.lo_mag  = lo_q[DIV_STEPS-1].quo;
  assign slab_o.lo_qneg = side_q[DIV_STEPS-1].lo_qneg;
  assign slab_o.hi_mag  = hi_q[DIV_STEPS-1].quo;
  assign slab_o.hi_qneg = side_q[DIV_STEPS-1].hi_qneg;
  assign slab_o.swap    = side_q[DIV_STEPS-1].swap;
  assign slab_o.par     = side_q[DIV_STEPS-1].par;
  assign slab_o.in_slab = side_q[DIV_STEPS-1].in_slab;

endmodule

/* rtl/ray_obb_exit_distance.sv */
// ----------------------------------------------------------------------------
// ray_obb_exit_distance: ray exit distance from an oriented box, slab test
// Pipeline: 51 stages + output reg; the whole pipeline holds while the skid stage is full.
// Throughput: one item per cycle while the skid stage is empty; the 43-step slab dividers are fully pipelined.
// Reset: clears valid bits and config registers; no clearing pass.
// ----------------------------------------------------------------------------
module ray_obb_exit_distance (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  rod_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output rod_pkg::out_item_t out_item_o,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i
);
  import rod_pkg::*;

  // Configuration
  logic signed [CRD_W-1:0] org_q [3];
  logic [RAD_W-1:0]        rad_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_q[0] <= '0;
      org_q[1] <= '0;
      org_q[2] <= '0;
      rad_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_ORIGIN_X:    org_q[0] <= cfg_data_i;
        CFG_ORIGIN_Y:    org_q[1] <= cfg_data_i;
        CFG_ORIGIN_Z:    org_q[2] <= cfg_data_i;
        CFG_GROW_RADIUS: rad_q    <= cfg_data_i[RAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  logic                   en;
  logic [PIPE_STAGES-1:0] vld_q;
  logic                   skid_vld_q;

  assign en         = !skid_vld_q;
  assign in_ready_o = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PIPE_STAGES-2:0], in_valid_i};
    end
  end

  // Stage 1: offset, grown extents
  logic signed [UNIT_W-1:0] d1_q [3];
  logic signed [V_W-1:0]    v1_q [3];
  logic [EXT_W-1:0]         e1_q [3];
  logic signed [UNIT_W-1:0] q1_q [4];

  always_ff @(posedge clk_i) begin
    if (en) begin
      d1_q[0] <= in_item_i.dir_x;
      d1_q[1] <= in_item_i.dir_y;
      d1_q[2] <= in_item_i.dir_z;
      v1_q[0] <= V_W'(org_q[0]) - V_W'(in_item_i.box_center_x);
      v1_q[1] <= V_W'(org_q[1]) - V_W'(in_item_i.box_center_y);
      v1_q[2] <= V_W'(org_q[2]) - V_W'(in_item_i.box_center_z);
      for (int a = 0; a < 3; a++) begin
        e1_q[a] <= EXT_W'(in_item_i.half_extents_packed[a*16 +: 16]) + EXT_W'(rad_q);
      end
      q1_q[0] <= in_item_i.quat_w;
      q1_q[1] <= in_item_i.quat_x;
      q1_q[2] <= in_item_i.quat_y;
      q1_q[3] <= in_item_i.quat_z;
    end
  end

  // Stage 2: quaternion products
  logic signed [UNIT_W-1:0] d2_q [3];
  logic signed [V_W-1:0]    v2_q [3];
  logic [EXT_W-1:0]         e2_q [3];
  logic signed [QP_W-1:0]   pxx_q, pyy_q, pzz_q, pxy_q, pxz_q, pyz_q, pwx_q, pwy_q, pwz_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d2_q  <= d1_q;
      v2_q  <= v1_q;
      e2_q  <= e1_q;
      pxx_q <= QP_W'(q1_q[1]) * QP_W'(q1_q[1]);
      pyy_q <= QP_W'(q1_q[2]) * QP_W'(q1_q[2]);
      pzz_q <= QP_W'(q1_q[3]) * QP_W'(q1_q[3]);
      pxy_q <= QP_W'(q1_q[1]) * QP_W'(q1_q[2]);
      pxz_q <= QP_W'(q1_q[1]) * QP_W'(q1_q[3]);
      pyz_q <= QP_W'(q1_q[2]) * QP_W'(q1_q[3]);
      pwx_q <= QP_W'(q1_q[0]) * QP_W'(q1_q[1]);
      pwy_q <= QP_W'(q1_q[0]) * QP_W'(q1_q[2]);
      pwz_q <= QP_W'(q1_q[0]) * QP_W'(q1_q[3]);
    end
  end

  // Stage 3: rotation matrix, Q28
  logic signed [UNIT_W-1:0] d3_q [3];
  logic signed [V_W-1:0]    v3_q [3];
  logic [EXT_W-1:0]         e3_q [3];
  logic signed [R_W-1:0]    r3_d [3][3];
  logic signed [R_W-1:0]    r3_q [3][3];

  always_comb begin
    r3_d[0][0] = R_W'(ONE_Q28 - ((RS_W'(pyy_q) + RS_W'(pzz_q)) <<< 1));
    r3_d[0][1] = R_W'((RS_W'(pxy_q) - RS_W'(pwz_q)) <<< 1);
    r3_d[0][2] = R_W'((RS_W'(pxz_q) + RS_W'(pwy_q)) <<< 1);
    r3_d[1][0] = R_W'((RS_W'(pxy_q) + RS_W'(pwz_q)) <<< 1);
    r3_d[1][1] = R_W'(ONE_Q28 - ((RS_W'(pxx_q) + RS_W'(pzz_q)) <<< 1));
    r3_d[1][2] = R_W'((RS_W'(pyz_q) - RS_W'(pwx_q)) <<< 1);
    r3_d[2][0] = R_W'((RS_W'(pxz_q) - RS_W'(pwy_q)) <<< 1);
    r3_d[2][1] = R_W'((RS_W'(pyz_q) + RS_W'(pwx_q)) <<< 1);
    r3_d[2][2] = R_W'(ONE_Q28 - ((RS_W'(pxx_q) + RS_W'(pyy_q)) <<< 1));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      d3_q <= d2_q;
      v3_q <= v2_q;
      e3_q <= e2_q;
      r3_q <= r3_d;
    end
  end

  // Stage 4: matrix products, transpose applied (local[a] = sum_i r[i][a] * w[i])
  logic [EXT_W-1:0]       e4_q [3];
  logic signed [PV_W-1:0] pv4_q [3][3];
  logic signed [PD_W-1:0] pd4_q [3][3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      e4_q <= e3_q;
      for (int i = 0; i < 3; i++) begin
        for (int a = 0; a < 3; a++) begin
          pv4_q[i][a] <= PV_W'(r3_q[i][a]) * PV_W'(v3_q[i]);
          pd4_q[i][a] <= PD_W'(r3_q[i][a]) * PD_W'(d3_q[i]);
        end
      end
    end
  end

  // Stage 5: sums, floor to local offset and direction
  logic [EXT_W-1:0]        e5_q [3];
  logic signed [LOC_W-1:0] loc5_q [3];
  logic signed [DIR_W-1:0] dir5_q [3];
  logic signed [SV_W-1:0]  sv5 [3];
  logic signed [SD_W-1:0]  sd5 [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sv5[a] = SV_W'(pv4_q[0][a]) + SV_W'(pv4_q[1][a]) + SV_W'(pv4_q[2][a]);
      sd5[a] = SD_W'(pd4_q[0][a]) + SD_W'(pd4_q[1][a]) + SD_W'(pd4_q[2][a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e5_q <= e4_q;
      for (int a = 0; a < 3; a++) begin
        loc5_q[a] <= LOC_W'(sv5[a] >>> LOC_SH);
        dir5_q[a] <= DIR_W'(sd5[a] >>> DIR_SH);
      end
    end
  end

  // Stage 6: slab numerators, parallel and in-slab tests
  slab_in_t                si6_d [3];
  slab_in_t                si6_q [3];
  logic [E16_W-1:0]        e16 [3];
  logic signed [NUM_W:0]   e16s [3];
  logic signed [NUM_W:0]   locs [3];
  logic signed [NUM_W:0]   nlo [3];
  logic signed [NUM_W:0]   nhi [3];
  logic [LOC_W-1:0]        lmag [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      e16[a]  = {e5_q[a], 8'b0};
      e16s[a] = $signed((NUM_W+1)'(e16[a]));
      locs[a] = (NUM_W+1)'(loc5_q[a]);
      nlo[a]  = -e16s[a] - locs[a];
      nhi[a]  = e16s[a] - locs[a];
      lmag[a] = loc5_q[a][LOC_W-1] ? LOC_W'(-loc5_q[a]) : LOC_W'(loc5_q[a]);
      si6_d[a].lo_mag  = nlo[a][NUM_W] ? NUM_W'(-nlo[a]) : NUM_W'(nlo[a]);
      si6_d[a].hi_mag  = nhi[a][NUM_W] ? NUM_W'(-nhi[a]) : NUM_W'(nhi[a]);
      si6_d[a].lo_qneg = nlo[a][NUM_W] ^ dir5_q[a][DIR_W-1];
      si6_d[a].hi_qneg = nhi[a][NUM_W] ^ dir5_q[a][DIR_W-1];
      si6_d[a].den_mag = dir5_q[a][DIR_W-1] ? DEN_W'(-dir5_q[a]) : DEN_W'(dir5_q[a]);
      si6_d[a].swap    = dir5_q[a][DIR_W-1];
      si6_d[a].par     = si6_d[a].den_mag < DEN_W'(PARALLEL_LIMIT);
      si6_d[a].in_slab = lmag[a] <= LOC_W'(e16[a]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      si6_q <= si6_d;
    end
  end

  // Slab dividers
  slab_out_t so [3];

  for (genvar a = 0; a < 3; a++) begin : g_axis
    rod_slab_div u_div (
      .clk_i  (clk_i),
      .en_i   (en),
      .slab_i (si6_q[a]),
      .slab_o (so[a])
    );
  end

  // Stage A: signed bounds, ordered by the direction sign
  logic signed [QT_W-1:0] lo_s [3];
  logic signed [QT_W-1:0] hi_s [3];
  logic signed [QT_W-1:0] a_lo_q [3];
  logic signed [QT_W-1:0] a_hi_q [3];
  logic [2:0]             a_par_q, a_in_q;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_s[a] = so[a].lo_qneg ? -$signed(QT_W'(so[a].lo_mag)) : $signed(QT_W'(so[a].lo_mag));
      hi_s[a] = so[a].hi_qneg ? -$signed(QT_W'(so[a].hi_mag)) : $signed(QT_W'(so[a].hi_mag));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int a = 0; a < 3; a++) begin
        a_lo_q[a]  <= so[a].swap ? hi_s[a] : lo_s[a];
        a_hi_q[a]  <= so[a].swap ? lo_s[a] : hi_s[a];
        a_par_q[a] <= so[a].par;
        a_in_q[a]  <= so[a].in_slab;
      end
    end
  end

  // Stage B: interval over the non-parallel axes, miss flag from the parallel axes
  logic signed [QT_W-1:0] ent_d, lev_d, b_ent_q, b_lev_q;
  logic                   has_d, miss_d, b_has_q, b_miss_q;

  always_comb begin
    has_d  = 1'b0;
    miss_d = 1'b0;
    ent_d  = '0;
    lev_d  = '0;
    for (int a = 0; a < 3; a++) begin
      if (a_par_q[a]) begin
        if (!a_in_q[a]) miss_d = 1'b1;
      end else begin
        if (!has_d || a_lo_q[a] > ent_d) ent_d = a_lo_q[a];
        if (!has_d || a_hi_q[a] < lev_d) lev_d = a_hi_q[a];
        has_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_ent_q  <= ent_d;
      b_lev_q  <= lev_d;
      b_has_q  <= has_d;
      b_miss_q <= miss_d;
    end
  end

  // Result
  out_item_t res;

  always_comb begin
    res = '0;
    if (b_miss_q) begin
      res = '0;
    end else if (!b_has_q) begin
      // parallel on every axis and within every slab: unbounded exit
      res.exit_distance = EXIT_MAX;
      res.box_hit       = 1'b1;
    end else if (!(b_lev_q < b_ent_q) && b_lev_q > 0) begin
      res.exit_distance = (b_lev_q > $signed(QT_W'(EXIT_MAX))) ? EXIT_MAX
                                                               : b_lev_q[DIST_W-1:0];
      res.box_hit       = 1'b1;
    end
  end

  // Output register with skid stage
  logic      arrive, out_take, out_vld_q;
  out_item_t out_q, skid_q;

  assign arrive   = en && vld_q[PIPE_STAGES-1];
  assign out_take = out_vld_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (skid_vld_q) begin
      if (out_take) begin
        out_vld_q  <= 1'b1;
        skid_vld_q <= 1'b0;
      end
    end else if (!out_vld_q || out_take) begin
      out_vld_q <= arrive;
    end else if (arrive) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_vld_q) begin
      if (out_take) out_q <= skid_q;
    end else if (!out_vld_q || out_take) begin
      out_q <= res;
    end else begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_item_o  = out_q;

endmodule

/* rtl/rod_chk.sv */
// ----------------------------------------------------------------------------
// rod_chk
// Port-level checks for the ray / oriented-box exit distance block.
// ----------------------------------------------------------------------------
module rod_chk (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input rod_pkg::out_item_t out_item_o
);
  import rod_pkg::*;

  `include "assert_macros.svh"

  // hold a stalled result
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i, $stable(out_item_o))
  // input stalls only behind a waiting result
  `ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, !in_ready_o, out_valid_o)
  `ASSERT_IMPL(a_miss_zero, clk_i, rst_ni, out_valid_o && !out_item_o.box_hit, out_item_o.exit_distance == '0)
  `ASSERT_IMPL(a_hit_ahead, clk_i, rst_ni, out_valid_o && out_item_o.box_hit, out_item_o.exit_distance != '0)

endmodule

bind ray_obb_exit_distance rod_chk u_rod_chk (.*);
